[src/periodic_cell_wrap_top_assert.svh]
// Assertion macros for the periodic cell wrap block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef PERIODIC_CELL_WRAP_TOP_ASSERT_SVH
`define PERIODIC_CELL_WRAP_TOP_ASSERT_SVH

// The property must hold at every clock edge.
`define PCW_ASSERT_NOW(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PCW_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/pcw_pkg.sv]
package pcw_pkg;

  localparam int INV_W     = 32;
  localparam int DIAG_W    = 31;
  localparam int TILT_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MASK_W    = 3;

  localparam logic signed [INV_W-1:0] INV_MAX = 32'sh7fff_ffff;
  localparam logic signed [INV_W-1:0] INV_MIN = 32'sh8000_0000;

  localparam logic [MASK_W-1:0] PERIODIC_ALL = 3'b111;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_AX  = 3'd0,
    REG_TILT_XY  = 3'd1,
    REG_TILT_XZ  = 3'd2,
    REG_CELL_BY  = 3'd3,
    REG_TILT_YZ  = 3'd4,
    REG_CELL_CZ  = 3'd5,
    REG_PER_MASK = 3'd6
  } reg_idx_e;

endpackage

[src/pcw_if.sv]
interface pcw_pos_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface pcw_wrap_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] wrapped_x;
  logic signed [COORD_WIDTH-1:0] wrapped_y;
  logic signed [COORD_WIDTH-1:0] wrapped_z;
  logic                          unsupported;

  modport source (output valid, wrapped_x, wrapped_y, wrapped_z, unsupported, input ready);
  modport sink   (input valid, wrapped_x, wrapped_y, wrapped_z, unsupported, output ready);
endinterface

[src/pcw_recip.sv]
// Bit-serial restoring divider: round(2^NUM_EXP / divisor), one quotient bit a cycle.
module pcw_recip import pcw_pkg::*; #(
  parameter int NUM_W   = 33,
  parameter int NUM_EXP = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DIAG_W-1:0]       divisor_i,
  output logic                    done_o,
  output logic signed [INV_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DIAG_W-1:0] rem_q;
  logic [DIAG_W-1:0] div_q;
  logic [DIAG_W:0]   shifted;
  logic [DIAG_W:0]   diff;
  logic              ge;

  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // The rounding half of the divisor is folded into the dividend.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= (NUM_W'(1) << NUM_EXP) + NUM_W'(divisor_i[DIAG_W-1:1]);
      rem_q <= '0;
      quo_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      num_q <= num_q << 1;
      rem_q <= ge ? diff[DIAG_W-1:0] : shifted[DIAG_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = (|quo_q[NUM_W-1:INV_W-1]) ? INV_MAX : $signed(quo_q[INV_W-1:0]);

endmodule

[src/periodic_cell_wrap_top.sv]
// Triclinic periodic wrap: each position word is mapped to fractional coordinates
// through the stored inverse cell matrix, its integer part dropped, and mapped back
// through the cell matrix. Throughput is one word per cycle while no set-up runs and
// the output is not stalled; the pipeline stages are two multiply stages, a fraction
// stage and the output register, and an empty stage lets a new word enter while a
// result waits. After reset and after every register write the inverse is recomputed
// by a shared serial divider (three reciprocals) and a multiply step that forms and
// then rounds each product (seven products); pos_i.ready stays low meanwhile. With
// any axis non-periodic, results are zero and flagged unsupported.
`include "periodic_cell_wrap_top_assert.svh"

module periodic_cell_wrap_top import pcw_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pcw_pos_if.sink              pos_i,
  pcw_wrap_if.source           wrap_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int UW  = 2 * F;
  localparam int QW  = TILT_W + F + 1;
  localparam int SW  = (QW + 2 > W + 2) ? QW + 2 : W + 2;
  localparam int NW  = ((UW > DIAG_W) ? UW : DIAG_W) + 1;
  localparam int PW  = 2 * INV_W + 1;

  localparam logic [UW-1:0]          U_HALF   = UW'(1) << (F - 1);
  localparam logic signed [SW-1:0]   S_HALF   = SW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0]   OUT_MAX  = (SW'(1) <<< (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0]   OUT_MIN  = -OUT_MAX - SW'(1);
  localparam logic [1:0]             DIV_LAST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_MUL  = 4'b1000
  } seq_state_e;

  // Steps of the inverse set-up after the reciprocals.
  typedef enum logic [2:0] {
    OP_YZ_I22 = 3'd0,
    OP_I12    = 3'd1,
    OP_XY_I11 = 3'd2,
    OP_I01    = 3'd3,
    OP_XY_I12 = 3'd4,
    OP_XZ_I22 = 3'd5,
    OP_I02    = 3'd6
  } mul_op_e;

  function automatic logic signed [INV_W-1:0] rnd_sat(input logic signed [2*INV_W-1:0] p);
    logic signed [PW-1:0] s;
    s = (PW'(p) + (PW'(1) <<< (F - 1))) >>> F;
    if (s > PW'(INV_MAX)) return INV_MAX;
    if (s < PW'(INV_MIN)) return INV_MIN;
    return s[INV_W-1:0];
  endfunction

  function automatic logic signed [INV_W-1:0] neg_sat(input logic signed [INV_W-1:0] x);
    return (x == INV_MIN) ? INV_MAX : -x;
  endfunction

  function automatic logic signed [INV_W-1:0] add_sat(input logic signed [INV_W-1:0] a,
                                                       input logic signed [INV_W-1:0] b);
    logic signed [INV_W:0] s;
    s = (INV_W+1)'(a) + (INV_W+1)'(b);
    if (s > (INV_W+1)'(INV_MAX)) return INV_MAX;
    if (s < (INV_W+1)'(INV_MIN)) return INV_MIN;
    return s[INV_W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_out(input logic signed [SW-1:0] r);
    if (r > OUT_MAX) return OUT_MAX[W-1:0];
    if (r < OUT_MIN) return OUT_MIN[W-1:0];
    return r[W-1:0];
  endfunction

  // Configuration registers.
  logic [DIAG_W-1:0]        ax_q, by_q, cz_q;
  logic signed [TILT_W-1:0] xy_q, xz_q, yz_q;
  logic [MASK_W-1:0]        mask_q;
  logic [DIAG_W-1:0]        diag_wr;
  logic                     cfg_hit;

  // Inverse matrix and set-up sequencer.
  logic signed [INV_W-1:0]   i00_q, i01_q, i02_q, i11_q, i12_q, i22_q;
  logic signed [INV_W-1:0]   tmp_a_q, tmp_b_q;
  logic signed [2*INV_W-1:0] prod_q;
  logic signed [INV_W-1:0]   op_a, op_b, rv;
  seq_state_e                state_q, state_d;
  mul_op_e                   op_q, op_d;
  logic                      ph_q, ph_d;
  logic [1:0]                sel_q, sel_d;
  logic                      div_start, div_done, busy;
  logic [DIAG_W-1:0]         div_in;
  logic signed [INV_W-1:0]   div_quot;

  // Pipeline.
  logic                    v1_q, v2_q, v3_q, v4_q;
  logic                    en1, en2, en3, en4, acc;
  logic [UW-1:0]           m00, m01, m02, m11, m12, m22;
  logic [UW-1:0]           p00_q, p01_q, p02_q, p11_q, p12_q, p22_q;
  logic [UW-1:0]           s0, s1, s2;
  logic [F-1:0]            u0_q, u1_q, u2_q;
  logic signed [QW-1:0]    q_ax_q, q_xy_q, q_xz_q, q_by_q, q_yz_q, q_cz_q;
  logic signed [SW-1:0]    sx, sy, sz;
  logic signed [W-1:0]     wx_q, wy_q, wz_q;
  logic                    unsup_q;
  logic                    wrap_zero;

  assign diag_wr = (cfg_data_i[DIAG_W-1:0] == '0) ? DIAG_W'(1) : cfg_data_i[DIAG_W-1:0];
  assign cfg_hit = cfg_we_i && (cfg_idx_i <= REG_PER_MASK);
  assign busy    = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q   <= DIAG_W'(65536);
      by_q   <= DIAG_W'(65536);
      cz_q   <= DIAG_W'(65536);
      xy_q   <= '0;
      xz_q   <= '0;
      yz_q   <= '0;
      mask_q <= PERIODIC_ALL;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CELL_AX:  ax_q   <= diag_wr;
        REG_TILT_XY:  xy_q   <= $signed(cfg_data_i[TILT_W-1:0]);
        REG_TILT_XZ:  xz_q   <= $signed(cfg_data_i[TILT_W-1:0]);
        REG_CELL_BY:  by_q   <= diag_wr;
        REG_TILT_YZ:  yz_q   <= $signed(cfg_data_i[TILT_W-1:0]);
        REG_CELL_CZ:  cz_q   <= diag_wr;
        REG_PER_MASK: mask_q <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel_q)
      2'd1:    div_in = by_q;
      2'd2:    div_in = cz_q;
      default: div_in = ax_q;
    endcase
  end

  pcw_recip #(
    .NUM_W   (NW),
    .NUM_EXP (UW)
  ) u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (div_in),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    unique case (op_q)
      OP_YZ_I22: begin op_a = yz_q;    op_b = i22_q; end
      OP_I12:    begin op_a = tmp_a_q; op_b = i11_q; end
      OP_XY_I11: begin op_a = xy_q;    op_b = i11_q; end
      OP_I01:    begin op_a = tmp_a_q; op_b = i00_q; end
      OP_XY_I12: begin op_a = xy_q;    op_b = i12_q; end
      OP_XZ_I22: begin op_a = xz_q;    op_b = i22_q; end
      OP_I02:    begin op_a = tmp_a_q; op_b = i00_q; end
      default:   begin op_a = '0;      op_b = '0;    end
    endcase
  end

  assign rv = rnd_sat(prod_q);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    ph_d      = ph_q;
    sel_d     = sel_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (sel_q == DIV_LAST) begin
            state_d = ST_MUL;
            op_d    = OP_YZ_I22;
            ph_d    = 1'b0;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_MUL: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if (op_q == OP_I02) state_d = ST_IDLE;
          else op_d = mul_op_e'(op_q + 3'd1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Any register write starts the set-up over.
    if (cfg_hit) begin
      state_d = ST_LOAD;
      sel_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      op_q    <= OP_YZ_I22;
      ph_q    <= 1'b0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ph_q    <= ph_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_done) begin
      unique case (sel_q)
        2'd1:    i11_q <= div_quot;
        2'd2:    i22_q <= div_quot;
        default: i00_q <= div_quot;
      endcase
    end
    if (state_q == ST_MUL) begin
      if (!ph_q) begin
        prod_q <= op_a * op_b;
      end else begin
        unique case (op_q)
          OP_YZ_I22: tmp_a_q <= rv;
          OP_I12:    i12_q   <= neg_sat(rv);
          OP_XY_I11: tmp_a_q <= rv;
          OP_I01:    i01_q   <= neg_sat(rv);
          OP_XY_I12: tmp_b_q <= rv;
          OP_XZ_I22: tmp_a_q <= add_sat(tmp_b_q, rv);
          OP_I02:    i02_q   <= neg_sat(rv);
          default: ;
        endcase
      end
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  assign en4         = !v4_q || wrap_o.ready;
  assign en3         = !v3_q || en4;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign pos_i.ready = en1 && !busy;
  assign acc         = pos_i.valid && pos_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= acc;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Only the low 2F bits of the products matter: the fraction sits in [2F-1:F].
  assign m00 = UW'(pos_i.pos_x) * UW'(i00_q);
  assign m01 = UW'(pos_i.pos_y) * UW'(i01_q);
  assign m02 = UW'(pos_i.pos_z) * UW'(i02_q);
  assign m11 = UW'(pos_i.pos_y) * UW'(i11_q);
  assign m12 = UW'(pos_i.pos_z) * UW'(i12_q);
  assign m22 = UW'(pos_i.pos_z) * UW'(i22_q);

  assign s0 = p00_q + p01_q + p02_q + U_HALF;
  assign s1 = p11_q + p12_q + U_HALF;
  assign s2 = p22_q + U_HALF;

  assign sx = ((SW'(q_ax_q) + SW'(q_xy_q) + SW'(q_xz_q)) + S_HALF) >>> F;
  assign sy = ((SW'(q_by_q) + SW'(q_yz_q)) + S_HALF) >>> F;
  assign sz = (SW'(q_cz_q) + S_HALF) >>> F;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p00_q <= m00;
      p01_q <= m01;
      p02_q <= m02;
      p11_q <= m11;
      p12_q <= m12;
      p22_q <= m22;
    end
    if (en2) begin
      u0_q <= s0[UW-1:F];
      u1_q <= s1[UW-1:F];
      u2_q <= s2[UW-1:F];
    end
    if (en3) begin
      q_ax_q <= QW'($signed({1'b0, ax_q})) * QW'($signed({1'b0, u0_q}));
      q_xy_q <= QW'(xy_q) * QW'($signed({1'b0, u1_q}));
      q_xz_q <= QW'(xz_q) * QW'($signed({1'b0, u2_q}));
      q_by_q <= QW'($signed({1'b0, by_q})) * QW'($signed({1'b0, u1_q}));
      q_yz_q <= QW'(yz_q) * QW'($signed({1'b0, u2_q}));
      q_cz_q <= QW'($signed({1'b0, cz_q})) * QW'($signed({1'b0, u2_q}));
    end
    if (en4) begin
      unsup_q <= (mask_q != PERIODIC_ALL);
      wx_q    <= (mask_q != PERIODIC_ALL) ? '0 : sat_out(sx);
      wy_q    <= (mask_q != PERIODIC_ALL) ? '0 : sat_out(sy);
      wz_q    <= (mask_q != PERIODIC_ALL) ? '0 : sat_out(sz);
    end
  end

  assign wrap_o.valid       = v4_q;
  assign wrap_o.wrapped_x   = wx_q;
  assign wrap_o.wrapped_y   = wy_q;
  assign wrap_o.wrapped_z   = wz_q;
  assign wrap_o.unsupported = unsup_q;

  assign wrap_zero = (wx_q == '0) && (wy_q == '0) && (wz_q == '0);

  `PCW_ASSERT_NOW(a_no_accept_busy, busy |-> !pos_i.ready, "word accepted during set-up")
  `PCW_ASSERT_NEXT(a_cfg_restart, cfg_hit, busy, "register write did not start set-up")
  `PCW_ASSERT_NOW(a_unsup_zero, v4_q && unsup_q |-> wrap_zero, "unsupported word not zero")
  `PCW_ASSERT_NEXT(a_accept_fills, acc, v1_q, "accepted word lost at first stage")

endmodule
